/* rtl/tlb_hit_miss_tracker_assert.svh */
// Assertion macros used by the TLB hit/miss tracker assertion monitor
`ifndef TLB_HIT_MISS_TRACKER_ASSERT_SVH
`define TLB_HIT_MISS_TRACKER_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while in reset
`define TLBHMT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset
`define TLBHMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tlbhmt_pkg.sv */
// Types, constants and register codes for the TLB hit/miss tracker
`default_nettype none

package tlbhmt_pkg;

    // Fixed field widths
    localparam int VADDR_W    = 64;
    localparam int BYTES_W    = 8;
    localparam int PAGE_OUT_W = 64;
    localparam int CNT_W      = 32;
    localparam int SHIFT_W    = 5;
    localparam int ENTRIES_W  = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Parameter defaults
    localparam int MAX_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF   = 64;

    // Register reset values
    localparam logic [SHIFT_W-1:0]   RST_PAGE_SHIFT   = 5'd12;
    localparam logic [ENTRIES_W-1:0] RST_TLB_ENTRIES  = 7'd64;
    localparam logic                 RST_USE_LRU      = 1'b1;
    localparam logic [CNT_W-1:0]     RST_FLUSH_PERIOD = 32'd0;
    localparam logic                 RST_SKIP_INSTR   = 1'b0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TLB_ENTRIES  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_LRU      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_INSTR   = 3'd4;

    typedef struct packed {
        logic [VADDR_W-1:0] virt_address;
        logic [BYTES_W-1:0] access_bytes;
        logic               is_fetch;
    } t_in_item;

    typedef struct packed {
        logic [PAGE_OUT_W-1:0] page_number;
        logic                  hit;
        logic                  flushed;
        logic                  last;
        logic [CNT_W-1:0]      lookup_count;
        logic [CNT_W-1:0]      miss_count;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_START,
        ST_SEARCH,
        ST_DECIDE,
        ST_SHIFT,
        ST_INSERT,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic idle;
        logic capture;
        logic prep;
        logic start;
        logic search;
        logic decide;
        logic shift;
        logic insert;
        logic emit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic drop;
        logic hit_now;
        logic search_miss;
        logic shift_done;
        logic out_free;
        logic two;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/tlbhmt_ctrl.sv */
// Sequencer for the TLB hit/miss tracker: one lookup at a time
`default_nettype none

module tlbhmt_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire tlbhmt_pkg::t_dp_stat  i_stat,
    output tlbhmt_pkg::t_ctrl_cmd      o_cmd
);

    tlbhmt_pkg::t_state r_state;
    tlbhmt_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlbhmt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlbhmt_pkg::ST_IDLE: begin
                if (i_in_valid && !i_stat.drop) n_state = tlbhmt_pkg::ST_PREP;
            end
            tlbhmt_pkg::ST_PREP:   n_state = tlbhmt_pkg::ST_START;
            tlbhmt_pkg::ST_START:  n_state = tlbhmt_pkg::ST_SEARCH;
            tlbhmt_pkg::ST_SEARCH: begin
                if (i_stat.hit_now || i_stat.search_miss) n_state = tlbhmt_pkg::ST_DECIDE;
            end
            tlbhmt_pkg::ST_DECIDE: n_state = tlbhmt_pkg::ST_SHIFT;
            tlbhmt_pkg::ST_SHIFT: begin
                if (i_stat.shift_done) n_state = tlbhmt_pkg::ST_INSERT;
            end
            tlbhmt_pkg::ST_INSERT: n_state = tlbhmt_pkg::ST_EMIT;
            tlbhmt_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.two ? tlbhmt_pkg::ST_START : tlbhmt_pkg::ST_IDLE;
                end
            end
            default: n_state = tlbhmt_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.idle    = (r_state == tlbhmt_pkg::ST_IDLE);
        o_cmd.capture = (r_state == tlbhmt_pkg::ST_IDLE) && i_in_valid;
        o_cmd.prep    = (r_state == tlbhmt_pkg::ST_PREP);
        o_cmd.start   = (r_state == tlbhmt_pkg::ST_START);
        o_cmd.search  = (r_state == tlbhmt_pkg::ST_SEARCH);
        o_cmd.decide  = (r_state == tlbhmt_pkg::ST_DECIDE);
        o_cmd.shift   = (r_state == tlbhmt_pkg::ST_SHIFT);
        o_cmd.insert  = (r_state == tlbhmt_pkg::ST_INSERT);
        o_cmd.emit    = (r_state == tlbhmt_pkg::ST_EMIT);
    end

endmodule

`default_nettype wire

/* rtl/tlbhmt_dp.sv */
// Datapath: config registers, counters, age-ordered page memory, output register
`default_nettype none

module tlbhmt_dp #(
    parameter int MAX_ENTRIES = tlbhmt_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = tlbhmt_pkg::ADDR_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    input  wire logic [tlbhmt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [tlbhmt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire tlbhmt_pkg::t_in_item                  i_in_data,
    input  wire tlbhmt_pkg::t_ctrl_cmd                 i_cmd,
    output tlbhmt_pkg::t_dp_stat                       o_stat,
    input  wire logic                                  i_out_stall,
    output logic                                       o_out_valid,
    output tlbhmt_pkg::t_out_item                      o_out_data
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int TW = (CW > tlbhmt_pkg::ENTRIES_W) ? CW : tlbhmt_pkg::ENTRIES_W;

    // Configuration
    logic [tlbhmt_pkg::SHIFT_W-1:0]   r_page_shift;
    logic [tlbhmt_pkg::ENTRIES_W-1:0] r_tlb_entries;
    logic                             r_use_lru;
    logic [tlbhmt_pkg::CNT_W-1:0]     r_flush_period;
    logic                             r_skip;

    // Control state
    logic [tlbhmt_pkg::CNT_W-1:0]     r_flush_cd;
    logic [tlbhmt_pkg::CNT_W-1:0]     r_lookups;
    logic [tlbhmt_pkg::CNT_W-1:0]     r_misses;
    logic [CW-1:0]                    r_vc;
    logic                             r_out_valid;
    logic                             n_out_valid;

    // Working registers
    logic [ADDR_BITS-1:0]             r_addr;
    logic [ADDR_BITS-1:0]             r_end;
    logic [ADDR_BITS-1:0]             r_page;
    logic [ADDR_BITS-1:0]             r_page_b;
    logic                             r_two;
    logic                             r_flushed;
    logic [CW-1:0]                    r_idx;
    logic                             r_rd_vld;
    logic [AW-1:0]                    r_rd_pos;
    logic [ADDR_BITS-1:0]             r_rdata;
    logic                             r_hit;
    logic [AW-1:0]                    r_pos;
    logic                             r_do_ins;
    logic [AW-1:0]                    r_sh;
    logic                             r_wr_pend;
    logic [AW-1:0]                    r_wr_pos;
    tlbhmt_pkg::t_out_item            r_out;

    // Pages by age: slot 0 is the most recent, slots below r_vc are live
    logic [ADDR_BITS-1:0]             r_mem [MAX_ENTRIES];

    logic [tlbhmt_pkg::BYTES_W-1:0]   bytes_m1;
    logic [ADDR_BITS-1:0]             in_addr;
    logic [ADDR_BITS-1:0]             first_page;
    logic [ADDR_BITS-1:0]             last_page;
    logic [TW-1:0]                    tlb_ext;
    logic [CW-1:0]                    cap;
    logic [CW-1:0]                    vc_trunc;
    logic                             hit_now;
    logic                             search_end;
    logic                             rd_search;
    logic                             rd_shift;
    logic                             rd_en;
    logic [AW-1:0]                    rd_addr;
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [ADDR_BITS-1:0]             wr_data;
    logic                             out_free;

    // Address span: zero size counts as one byte
    assign bytes_m1 = (i_in_data.access_bytes == '0) ? '0 : i_in_data.access_bytes - 1'b1;
    assign in_addr  = i_in_data.virt_address[ADDR_BITS-1:0];

    assign first_page = r_addr >> r_page_shift;
    assign last_page  = r_end >> r_page_shift;

    // Effective capacity, clamped to 1..MAX_ENTRIES
    assign tlb_ext = TW'(r_tlb_entries);
    always_comb begin
        if (r_tlb_entries == '0) begin
            cap = CW'(1);
        end else if (tlb_ext > TW'(MAX_ENTRIES)) begin
            cap = CW'(MAX_ENTRIES);
        end else begin
            cap = CW'(tlb_ext);
        end
    end

    // Entries kept on a miss: drop the oldest until one slot is free
    assign vc_trunc = (r_vc >= cap) ? cap - 1'b1 : r_vc;

    // Search compare on the registered read data
    assign hit_now    = r_rd_vld && (r_rdata == r_page);
    assign search_end = (r_idx == r_vc);
    assign rd_search  = i_cmd.search && !hit_now && !search_end;
    assign rd_shift   = i_cmd.shift && (r_sh != '0);

    // Memory port muxing
    assign rd_en   = rd_search || rd_shift;
    assign rd_addr = rd_shift ? r_sh - 1'b1 : r_idx[AW-1:0];
    assign wr_en   = (i_cmd.shift && r_wr_pend) || (i_cmd.insert && r_do_ins);
    assign wr_addr = i_cmd.insert ? '0 : r_wr_pos;
    assign wr_data = i_cmd.insert ? r_page : r_rdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= r_mem[rd_addr];
    end

    // Output register
    assign out_free = !r_out_valid || !i_out_stall;
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (i_cmd.emit && out_free) n_out_valid = 1'b1;
    end

    // Status back to the controller
    always_comb begin
        o_stat             = '0;
        o_stat.drop        = r_skip && i_in_data.is_fetch;
        o_stat.hit_now     = hit_now;
        o_stat.search_miss = !hit_now && search_end;
        o_stat.shift_done  = (r_sh == '0);
        o_stat.out_free    = out_free;
        o_stat.two         = r_two;
    end

    // Config, counters, fill count and flush countdown
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift   <= tlbhmt_pkg::RST_PAGE_SHIFT;
            r_tlb_entries  <= tlbhmt_pkg::RST_TLB_ENTRIES;
            r_use_lru      <= tlbhmt_pkg::RST_USE_LRU;
            r_flush_period <= tlbhmt_pkg::RST_FLUSH_PERIOD;
            r_skip         <= tlbhmt_pkg::RST_SKIP_INSTR;
            r_flush_cd     <= tlbhmt_pkg::RST_FLUSH_PERIOD;
            r_lookups      <= '0;
            r_misses       <= '0;
            r_vc           <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tlbhmt_pkg::CFG_PAGE_SHIFT:
                        r_page_shift <= i_cfg_data[tlbhmt_pkg::SHIFT_W-1:0];
                    tlbhmt_pkg::CFG_TLB_ENTRIES:
                        r_tlb_entries <= i_cfg_data[tlbhmt_pkg::ENTRIES_W-1:0];
                    tlbhmt_pkg::CFG_USE_LRU:
                        r_use_lru <= i_cfg_data[0];
                    tlbhmt_pkg::CFG_FLUSH_PERIOD: begin
                        r_flush_period <= i_cfg_data;
                        r_flush_cd     <= i_cfg_data;
                    end
                    tlbhmt_pkg::CFG_SKIP_INSTR:
                        r_skip <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Lookup start: count and periodic flush
            if (i_cmd.start) begin
                r_lookups <= r_lookups + 1'b1;
                if (r_flush_period != '0) begin
                    if (r_flush_cd <= 32'd1) begin
                        r_flush_cd <= r_flush_period;
                        r_vc       <= '0;
                    end else begin
                        r_flush_cd <= r_flush_cd - 1'b1;
                    end
                end
            end
            if (i_cmd.decide && !r_hit) begin
                r_misses <= r_misses + 1'b1;
                r_vc     <= vc_trunc;
            end
            if (i_cmd.insert && !r_hit) r_vc <= r_vc + 1'b1;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge i_clk) begin
        // Beat capture
        if (i_cmd.capture) begin
            r_addr <= in_addr;
            r_end  <= in_addr + ADDR_BITS'(bytes_m1);
        end
        // Page numbers for the access
        if (i_cmd.prep) begin
            r_page   <= first_page;
            r_page_b <= last_page;
            r_two    <= (first_page != last_page);
        end
        if (i_cmd.start) begin
            r_flushed <= (r_flush_period != '0) && (r_flush_cd <= 32'd1) && (r_vc != '0);
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
        end
        // Scan one slot a cycle
        if (i_cmd.search) begin
            r_rd_vld <= rd_search;
            r_rd_pos <= r_idx[AW-1:0];
            if (rd_search) r_idx <= r_idx + 1'b1;
            if (hit_now) begin
                r_hit <= 1'b1;
                r_pos <= r_rd_pos;
            end else if (search_end) begin
                r_hit <= 1'b0;
            end
        end
        // Pick how many slots move down one place
        if (i_cmd.decide) begin
            r_wr_pend <= 1'b0;
            if (r_hit) begin
                r_sh     <= r_use_lru ? r_pos : '0;
                r_do_ins <= r_use_lru;
            end else begin
                r_sh     <= AW'(vc_trunc);
                r_do_ins <= 1'b1;
            end
        end
        // Read slot k-1, write it to slot k next cycle
        if (i_cmd.shift) begin
            r_wr_pend <= rd_shift;
            if (rd_shift) begin
                r_sh     <= r_sh - 1'b1;
                r_wr_pos <= r_sh;
            end
        end
        // Result out; then move on to the last page
        if (i_cmd.emit && out_free) begin
            r_out.page_number  <= tlbhmt_pkg::PAGE_OUT_W'(r_page);
            r_out.hit          <= r_hit;
            r_out.flushed      <= r_flushed;
            r_out.last         <= !r_two;
            r_out.lookup_count <= r_lookups;
            r_out.miss_count   <= r_misses;
            if (r_two) begin
                r_page <= r_page_b;
                r_two  <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/tlb_hit_miss_tracker.sv */
// Top level of the TLB hit/miss tracker
//
//  channel | dir | handshake                 | beat
//  --------+-----+---------------------------+-----------------------------
//  in      | in  | i_in_valid / o_in_stall   | t_in_item: address, size, fetch
//  out     | out | o_out_valid / i_out_stall | t_out_item: one lookup result
//  cfg     | in  | i_cfg_valid / o_cfg_ready | register index and data
//
// One access at a time; a lookup scans the age-ordered page memory one slot per
// cycle, then moves slots on LRU promotion or insertion one per cycle.
// An access costs one or two lookups plus capture and page split.
// Synchronous active-low reset; no clearing pass, a fill count marks live slots.
// A stalled output holds its beat; the next lookup waits only to load it.
`default_nettype none

module tlb_hit_miss_tracker #(
    parameter int MAX_ENTRIES = tlbhmt_pkg::MAX_ENTRIES_DEF,
    parameter int ADDR_BITS   = tlbhmt_pkg::ADDR_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire tlbhmt_pkg::t_in_item                i_in_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output tlbhmt_pkg::t_out_item                    o_out_data,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tlbhmt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [tlbhmt_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    tlbhmt_pkg::t_ctrl_cmd cmd;
    tlbhmt_pkg::t_dp_stat  stat;

    // Config writes are always accepted and go straight into the registers
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !cmd.idle;

    tlbhmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tlbhmt_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/tlbhmt_assert_mon.sv */
// Port-level assertion monitor for the TLB hit/miss tracker, with its bind
`default_nettype none
`include "tlb_hit_miss_tracker_assert.svh"

module tlbhmt_assert_mon (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   o_in_stall,
    input wire tlbhmt_pkg::t_in_item   i_in_data,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_stall,
    input wire tlbhmt_pkg::t_out_item  o_out_data
);

    logic                             out_beat;
    logic                             in_beat;
    logic [tlbhmt_pkg::CNT_W-1:0]     r_lk_prev;
    logic [tlbhmt_pkg::CNT_W-1:0]     r_ms_prev;

    assign out_beat = o_out_valid && !i_out_stall;
    assign in_beat  = i_in_valid && !o_in_stall;

    // Counters seen on the previous result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_prev <= '0;
            r_ms_prev <= '0;
        end else if (out_beat) begin
            r_lk_prev <= o_out_data.lookup_count;
            r_ms_prev <= o_out_data.miss_count;
        end
    end

    // Stalled result holds
    `TLBHMT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")

    // A data access always goes to lookup, so the input closes behind it
    `TLBHMT_ASSERT_NEXT(a_busy_after_access, in_beat && !i_in_data.is_fetch, o_in_stall, "input open right after a data access")

    // Every result is exactly one lookup
    `TLBHMT_ASSERT_NOW(a_lookup_step, out_beat, o_out_data.lookup_count == r_lk_prev + 32'd1, "lookup count skipped")

    // Misses grow by one on a miss and hold on a hit
    `TLBHMT_ASSERT_NOW(a_miss_step, out_beat, o_out_data.miss_count == (o_out_data.hit ? r_ms_prev : r_ms_prev + 32'd1), "miss count mismatch")

endmodule

bind tlb_hit_miss_tracker tlbhmt_assert_mon u_assert_mon (.*);

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the TLB hit/miss tracker: mirror model, random stalls, config phases
`timescale 1ns / 1ps

module testbench;
    import tlbhmt_pkg::*;

    localparam int          MAX_ENTRIES = MAX_ENTRIES_DEF;
    localparam int          POOL_SIZE   = 100;
    // One access: capture and split plus two worst-case lookups, with margin
    localparam int          SETTLE      = 2 * (2 * MAX_ENTRIES + 8) + 24;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          MAX_REPORTS = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Mirror of the TLB: replacement state, counters and registers
    class tlb_mirror;
        logic [SHIFT_W-1:0]   page_shift;
        logic [ENTRIES_W-1:0] entry_limit;
        logic                 lru_mode;
        logic [CNT_W-1:0]     flush_period;
        logic                 skip_fetch;

        logic [63:0]  slot_page [MAX_ENTRIES];
        bit           slot_valid[MAX_ENTRIES];
        int unsigned  slot_age  [MAX_ENTRIES];
        int unsigned  live;
        logic [31:0]  lookups;
        logic [31:0]  misses;
        logic [31:0]  flush_left;

        t_out_item    expected_lookups[$];
        int unsigned  mismatches;

        function new();
            page_shift   = RST_PAGE_SHIFT;
            entry_limit  = RST_TLB_ENTRIES;
            lru_mode     = RST_USE_LRU;
            flush_period = RST_FLUSH_PERIOD;
            skip_fetch   = RST_SKIP_INSTR;
            drop_all();
            lookups      = '0;
            misses       = '0;
            flush_left   = flush_period;
            mismatches   = 0;
        endfunction

        function void drop_all();
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                slot_valid[i] = 1'b0;
                slot_age[i]   = 0;
            end
            live = 0;
        endfunction

        function int unsigned capacity();
            if (entry_limit == 0) return 1;
            if (entry_limit > MAX_ENTRIES) return MAX_ENTRIES;
            return 32'(entry_limit);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_PAGE_SHIFT:   page_shift  = value[SHIFT_W-1:0];
                CFG_TLB_ENTRIES:  entry_limit = value[ENTRIES_W-1:0];
                CFG_USE_LRU:      lru_mode    = value[0];
                CFG_FLUSH_PERIOD: begin
                    flush_period = value;
                    flush_left   = value;
                end
                CFG_SKIP_INSTR:   skip_fetch  = value[0];
                default: ;
            endcase
        endfunction

        // One page lookup: periodic flush, search, promote or insert
        function void look_up(logic [63:0] page, bit is_last);
            t_out_item   r;
            bit          flushed;
            int          found;
            int unsigned a;
            int unsigned cap;
            flushed = 1'b0;
            found   = -1;
            lookups = lookups + 1;
            if (flush_period != 0) begin
                if (flush_left <= 1) begin
                    flush_left = flush_period;
                    if (live != 0) begin
                        drop_all();
                        flushed = 1'b1;
                    end
                end else begin
                    flush_left = flush_left - 1;
                end
            end

            for (int i = 0; i < MAX_ENTRIES; i++)
                if (found < 0 && slot_valid[i] && slot_page[i] == page) found = i;

            if (found >= 0) begin
                if (lru_mode) begin
                    a = slot_age[found];
                    for (int i = 0; i < MAX_ENTRIES; i++)
                        if (slot_valid[i] && slot_age[i] < a) slot_age[i]++;
                    slot_age[found] = 0;
                end
            end else begin
                cap    = capacity();
                misses = misses + 1;
                // evict everything at or past the oldest allowed age
                if (live >= cap) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (slot_valid[i] && slot_age[i] >= cap - 1) begin
                            slot_valid[i] = 1'b0;
                            slot_age[i]   = 0;
                            live--;
                        end
                    end
                end
                for (int i = 0; i < MAX_ENTRIES; i++)
                    if (slot_valid[i]) slot_age[i]++;
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (!slot_valid[i]) begin
                        slot_valid[i] = 1'b1;
                        slot_page[i]  = page;
                        slot_age[i]   = 0;
                        live++;
                        break;
                    end
                end
            end

            r.page_number  = page;
            r.hit          = (found >= 0);
            r.flushed      = flushed;
            r.last         = is_last;
            r.lookup_count = lookups;
            r.miss_count   = misses;
            expected_lookups.push_back(r);
        endfunction

        // Accepted access beat; returns the number of lookups it causes
        function int note_access(t_in_item a);
            logic [63:0] end_addr;
            logic [63:0] first_pg;
            logic [63:0] last_pg;
            logic [7:0]  nbytes;
            if (skip_fetch && a.is_fetch) return 0;
            nbytes   = (a.access_bytes == 0) ? 8'd1 : a.access_bytes;
            end_addr = a.virt_address + {56'd0, nbytes} - 64'd1;
            first_pg = a.virt_address >> page_shift;
            last_pg  = end_addr >> page_shift;
            if (first_pg == last_pg) begin
                look_up(first_pg, 1'b1);
                return 1;
            end
            look_up(first_pg, 1'b0);
            look_up(last_pg, 1'b1);
            return 2;
        endfunction

        function void report(string field, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_lookups.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none actual %h", $time, got);
                return;
            end
            want = expected_lookups.pop_front();
            if (got.page_number !== want.page_number)
                report("page_number", want.page_number, got.page_number);
            if (got.hit !== want.hit)
                report("hit", {63'd0, want.hit}, {63'd0, got.hit});
            if (got.flushed !== want.flushed)
                report("flushed", {63'd0, want.flushed}, {63'd0, got.flushed});
            if (got.last !== want.last)
                report("last", {63'd0, want.last}, {63'd0, got.last});
            if (got.lookup_count !== want.lookup_count)
                report("lookup_count", {32'd0, want.lookup_count}, {32'd0, got.lookup_count});
            if (got.miss_count !== want.miss_count)
                report("miss_count", {32'd0, want.miss_count}, {32'd0, got.miss_count});
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in_item              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    tlb_mirror   mirror = new();
    bit          calm   = 1'b0;
    int unsigned cycles = 0;
    logic [63:0] page_pool[POOL_SIZE];

    tlb_hit_miss_tracker DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** tlb_hit_miss_tracker: FAILED **");
            $finish;
        end
    end

    // Result monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) mirror.check_result(out_data);
    end

    // Receiver back-pressure: stall bursts between free stretches, none when calm
    initial begin
        forever begin
            if (calm) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
                if ($urandom_range(0, 4) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
                else repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    function automatic t_in_item mk(logic [63:0] addr, logic [7:0] nbytes, logic fetch);
        t_in_item a;
        a.virt_address = addr;
        a.access_bytes = nbytes;
        a.is_fetch     = fetch;
        return a;
    endfunction

    // Random access, mostly from a page pool sized around the TLB capacity
    function automatic t_in_item pick_access();
        t_in_item    a;
        logic [63:0] page;
        logic [63:0] page_bytes;
        logic [63:0] offset;
        int unsigned span;
        int unsigned roll;
        span = mirror.capacity() + mirror.capacity() / 2 + 2;
        if (span > POOL_SIZE) span = POOL_SIZE;
        roll = $urandom_range(0, 99);
        a.is_fetch     = ($urandom_range(0, 3) == 0);
        a.access_bytes = 8'($urandom_range(1, 255));
        if ($urandom_range(0, 15) == 0) a.access_bytes = 8'd0;
        if (roll < 8) begin
            a.virt_address = {$urandom, $urandom};
        end else if (roll < 12) begin
            // near the top of the address space, so the end wraps
            a.virt_address = ~64'd0 - $urandom_range(0, 300);
        end else begin
            page       = page_pool[$urandom_range(0, span - 1)];
            page_bytes = 64'd1 << mirror.page_shift;
            if (roll < 40) offset = page_bytes - $urandom_range(1, 200);
            else offset = {$urandom, $urandom} & (page_bytes - 1);
            a.virt_address = (page << mirror.page_shift) + offset;
        end
        return a;
    endfunction

    // Drive one access beat; valid stays high unless a gap follows
    task automatic send_access(input t_in_item a, output int produced);
        in_valid <= 1'b1;
        in_data  <= a;
        do @(posedge clk); while (in_stall);
        produced = mirror.note_access(a);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic run_random(input int count);
        int produced;
        int done;
        done = 0;
        while (done < count) begin
            send_access(pick_access(), produced);
            if (produced > 0) done++;
        end
    endtask

    // Hold the sender until every lookup is out and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        while (mirror.expected_lookups.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Back-to-back register writes, junk above each field, plus an unused index
    task automatic apply_setting(input logic [SHIFT_W-1:0] shift,
                                 input logic [ENTRIES_W-1:0] entries,
                                 input logic lru, input logic [CNT_W-1:0] period,
                                 input logic skip);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx[0] = CFG_PAGE_SHIFT;   val[0] = ($urandom << SHIFT_W) | shift;
        idx[1] = CFG_TLB_ENTRIES;  val[1] = ($urandom << ENTRIES_W) | entries;
        idx[2] = CFG_USE_LRU;      val[2] = ($urandom << 1) | lru;
        idx[3] = CFG_FLUSH_PERIOD; val[3] = period;
        idx[4] = CFG_SKIP_INSTR;   val[4] = ($urandom << 1) | skip;
        idx[5] = CFG_UNUSED;       val[5] = $urandom;
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge clk); while (!cfg_ready);
            mirror.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Main sequence
    initial begin
        int n;
        for (int i = 0; i < POOL_SIZE; i++) begin
            if (i % 10 == 9) page_pool[i] = {$urandom, $urandom};
            else page_pool[i] = 64'($urandom_range(0, 1 << 20));
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: boundaries, zero size, wrap, page crossings, fetches
        send_access(mk(64'd0, 8'd1, 1'b0), n);
        send_access(mk(64'd0, 8'd0, 1'b0), n);
        send_access(mk(64'hFFF, 8'd2, 1'b0), n);
        send_access(mk(~64'd0, 8'd1, 1'b0), n);
        send_access(mk(~64'd0, 8'd255, 1'b0), n);
        send_access(mk(64'hFFFF_FFFF_FFFF_F000, 8'd255, 1'b1), n);
        send_access(mk(64'h1000, 8'd255, 1'b1), n);
        send_access(mk(64'h1F01, 8'd255, 1'b0), n);
        send_access(mk(64'h1F02, 8'd255, 1'b0), n);
        send_access(mk(64'hAAAA_AAAA_AAAA_AAAA, 8'd128, 1'b0), n);
        send_access(mk(64'h5555_5555_5555_5555, 8'd127, 1'b1), n);
        send_access(mk(64'd0, 8'd255, 1'b0), n);
        run_random(150);
        drain();

        // Byte pages, single entry, FIFO, fetches skipped
        apply_setting(5'd0, 7'd1, 1'b0, 32'd0, 1'b1);
        send_access(mk(64'd0, 8'd1, 1'b1), n);
        send_access(mk(64'd0, 8'd1, 1'b0), n);
        send_access(mk(64'd1, 8'd1, 1'b0), n);
        send_access(mk(64'd0, 8'd2, 1'b0), n);
        run_random(100);
        drain();

        apply_setting(5'd16, 7'd4, 1'b1, 32'd7, 1'b0);
        run_random(150);
        drain();

        // Widest shift, entry count zero, flush before every lookup
        apply_setting(5'd31, 7'd0, 1'b1, 32'd1, 1'b1);
        run_random(60);
        drain();

        apply_setting(5'd6, 7'd16, 1'b0, 32'hFFFF_FFFF, 1'b0);
        run_random(120);
        drain();

        // Capacity lowered below the live entry count
        apply_setting(5'd6, 7'd3, 1'b0, 32'd5, 1'b0);
        run_random(100);
        drain();

        // Entry count above the maximum
        apply_setting(5'd17, 7'd127, 1'b1, 32'd0, 1'b1);
        run_random(80);
        drain();

        // Final stretch without idling on either side
        apply_setting(5'd12, 7'd64, 1'b1, 32'd13, 1'b0);
        calm = 1'b1;
        run_random(150);
        drain();

        if (mirror.mismatches == 0 && mirror.expected_lookups.size() == 0)
            $display("** tlb_hit_miss_tracker: PASSED **");
        else
            $display("** tlb_hit_miss_tracker: FAILED **");
        $finish;
    end

endmodule
